/* rtl/tvp_pkg.sv */
// Package for the turtle vector plotter: command codes, field widths,
// the CORDIC constants and the control word carried down the pipeline.
// No dependencies; every other file in rtl imports it.
package tvp_pkg;

  localparam int AngleBitsDef = 16;
  localparam int PosBitsDef   = 24;

  localparam int CMD_W    = 3;
  localparam int AMOUNT_W = 16;
  localparam int COLOR_W  = 3;
  localparam int COORD_W  = 24;

  localparam int CORDIC_ITERS = 16;
  localparam int CW           = 34;
  localparam int AMT_W        = 17;
  localparam int DISP_W       = 19;
  localparam int FRAC_BITS    = 30;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 104;

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    34'sh020000000, 34'sh012E4051D, 34'sh009FB385B, 34'sh0051111D4,
    34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
    34'sh00028BE53, 34'sh000145F2E, 34'sh0000A2F98, 34'sh0000517CC,
    34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2F9, 34'sh00000517C
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_FWD      = 3'd0,
    CMD_BACK     = 3'd1,
    CMD_RIGHT    = 3'd2,
    CMD_LEFT     = 3'd3,
    CMD_PEN_DOWN = 3'd4,
    CMD_PEN_UP   = 3'd5,
    CMD_HOME     = 3'd6,
    CMD_COLOR    = 3'd7
  } cmd_e;

  typedef struct packed {
    logic               is_move;
    logic               is_home;
    logic               pen;
    logic [COLOR_W-1:0] color;
  } tvp_ctl_t;

endpackage

/* rtl/turtle_vector_plotter.sv */
// Top level of the turtle vector plotter: command stream in, line segments out.
// Instantiates tvp_front, tvp_cordic, tvp_scale and tvp_pos; depends on tvp_pkg.
//
//   Channel  Direction  tdata (low bit first)                       tuser
//   s_axis   in         amount[15:0], color_index[2:0], 5'b0        cmd[2:0]
//   m_axis   out        start_x, start_y, end_x, end_y (24 b each),  none
//                       seg_color[2:0], clipped, 4'b0
//
// One item is accepted per cycle while m_axis does not stall the pipeline. A pen-down
// move's segment passes the input register, which loads at the accepting edge, then
// 16 CORDIC iteration stages, the scaling multiplier stage and the result register.
// Reset puts the turtle at (0, 1.0), heading zero, pen up, colour red.
// When a result waits and m_axis_tready_i is low, the whole pipeline holds.
module turtle_vector_plotter #(
  parameter int ANGLE_BITS = tvp_pkg::AngleBitsDef,
  parameter int POS_BITS   = tvp_pkg::PosBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // amount, color_index, zero padding
  input  logic [tvp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // cmd
  input  logic [tvp_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // start_x, start_y, end_x, end_y, seg_color, clipped, zero padding
  output logic [tvp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import tvp_pkg::*;

  logic                     adv;
  logic                     f_vld, c_vld, s_vld, out_vld;
  tvp_ctl_t                 f_ctl, c_ctl, s_ctl;
  logic signed [AMT_W-1:0]  f_amt, c_amt;
  logic signed [CW-1:0]     f_z, c_cos, c_sin;
  logic signed [DISP_W-1:0] s_dx, s_dy;
  logic [COORD_W-1:0]       sx, sy, ex, ey;
  logic [COLOR_W-1:0]       seg_color;
  logic                     clipped;

  assign adv             = ~out_vld | m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {4'b0, clipped, seg_color, ey, ex, sy, sx};

  tvp_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (s_axis_tvalid_i),
    .cmd_i    (cmd_e'(s_axis_tuser_i)),
    .amount_i ($signed(s_axis_tdata_i[AMOUNT_W-1:0])),
    .color_i  (s_axis_tdata_i[AMOUNT_W +: COLOR_W]),
    .vld_o    (f_vld),
    .ctl_o    (f_ctl),
    .amt_o    (f_amt),
    .z_o      (f_z)
  );

  tvp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (f_vld),
    .ctl_i  (f_ctl),
    .amt_i  (f_amt),
    .z_i    (f_z),
    .vld_o  (c_vld),
    .ctl_o  (c_ctl),
    .amt_o  (c_amt),
    .cos_o  (c_cos),
    .sin_o  (c_sin)
  );

  tvp_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (c_vld),
    .ctl_i  (c_ctl),
    .amt_i  (c_amt),
    .cos_i  (c_cos),
    .sin_i  (c_sin),
    .vld_o  (s_vld),
    .ctl_o  (s_ctl),
    .dx_o   (s_dx),
    .dy_o   (s_dy)
  );

  tvp_pos #(.POS_BITS(POS_BITS)) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .vld_i       (s_vld),
    .ctl_i       (s_ctl),
    .dx_i        (s_dx),
    .dy_i        (s_dy),
    .out_vld_o   (out_vld),
    .start_x_o   (sx),
    .start_y_o   (sy),
    .end_x_o     (ex),
    .end_y_o     (ey),
    .seg_color_o (seg_color),
    .clipped_o   (clipped)
  );

  a_result_from_pen_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld) |-> $past(s_vld && s_ctl.is_move && s_ctl.pen))
    else $error("result appeared without a pen-down move in the scaling stage");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s_vld) && $stable(c_vld) && $stable(f_vld))
    else $error("pipeline stage changed while the result was stalled");

  a_no_move_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !(s_vld && s_ctl.is_move) |=> !out_vld)
    else $error("result register loaded by a non-move item");

endmodule

/* rtl/tvp_front.sv */
// Command decode and input register of the turtle vector plotter.
// Holds heading, pen state and pen colour; folds the heading into the
// CORDIC range. Depends on tvp_pkg.
module tvp_front #(
  parameter int ANGLE_BITS = tvp_pkg::AngleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  tvp_pkg::cmd_e                       cmd_i,
  input  logic signed [tvp_pkg::AMOUNT_W-1:0] amount_i,
  input  logic [tvp_pkg::COLOR_W-1:0]         color_i,
  output logic                                vld_o,
  output tvp_pkg::tvp_ctl_t                   ctl_o,
  output logic signed [tvp_pkg::AMT_W-1:0]    amt_o,
  output logic signed [tvp_pkg::CW-1:0]       z_o
);
  import tvp_pkg::*;

  logic [ANGLE_BITS-1:0] heading_q, heading_d;
  logic                  pen_q, pen_d;
  logic [COLOR_W-1:0]    color_q, color_d;
  logic                  vld_q;
  tvp_ctl_t              ctl_q, ctl_d;
  logic signed [AMT_W-1:0] amt_q, amt_d, amt_ext;
  logic signed [CW-1:0]  z_q, z_d;
  logic [31:0]           th, th_fold;
  logic                  flip, accept;
  logic [ANGLE_BITS-1:0] turn;

  assign accept = valid_i & adv_i;
  assign th     = {heading_q, {(32-ANGLE_BITS){1'b0}}};
  assign flip   = th[31] ^ th[30];
  assign th_fold = {th[31] ^ flip, th[30:0]};
  assign turn   = ANGLE_BITS'(amount_i);
  assign amt_ext = AMT_W'(amount_i);

  always_comb begin
    heading_d = heading_q;
    pen_d     = pen_q;
    color_d   = color_q;
    ctl_d     = '{is_move: 1'b0, is_home: 1'b0, pen: pen_q, color: color_q};
    amt_d     = ((cmd_i == CMD_BACK) ^ flip) ? -amt_ext : amt_ext;
    z_d       = CW'($signed(th_fold));
    unique case (cmd_i)
      CMD_FWD, CMD_BACK: ctl_d.is_move = 1'b1;
      CMD_RIGHT:         heading_d = heading_q + turn;
      CMD_LEFT:          heading_d = heading_q - turn;
      CMD_PEN_DOWN:      pen_d = 1'b1;
      CMD_PEN_UP:        pen_d = 1'b0;
      CMD_HOME:          ctl_d.is_home = 1'b1;
      CMD_COLOR:         color_d = color_i;
      default:           ctl_d.is_move = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      pen_q     <= 1'b0;
      color_q   <= '0;
      vld_q     <= 1'b0;
    end else if (adv_i) begin
      vld_q <= accept;
      if (accept) begin
        heading_q <= heading_d;
        pen_q     <= pen_d;
        color_q   <= color_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q <= ctl_d;
      amt_q <= amt_d;
      z_q   <= z_d;
    end
  end

  assign vld_o = vld_q;
  assign ctl_o = ctl_q;
  assign amt_o = amt_q;
  assign z_o   = z_q;

endmodule

/* rtl/tvp_cordic.sv */
// Pipelined CORDIC rotation for the turtle vector plotter, one register
// stage per iteration, carrying the item's control word and length along.
// Depends on tvp_pkg.
module tvp_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             vld_i,
  input  tvp_pkg::tvp_ctl_t                ctl_i,
  input  logic signed [tvp_pkg::AMT_W-1:0] amt_i,
  input  logic signed [tvp_pkg::CW-1:0]    z_i,
  output logic                             vld_o,
  output tvp_pkg::tvp_ctl_t                ctl_o,
  output logic signed [tvp_pkg::AMT_W-1:0] amt_o,
  output logic signed [tvp_pkg::CW-1:0]    cos_o,
  output logic signed [tvp_pkg::CW-1:0]    sin_o
);
  import tvp_pkg::*;

  logic signed [CW-1:0]    x_in [CORDIC_ITERS];
  logic signed [CW-1:0]    y_in [CORDIC_ITERS];
  logic signed [CW-1:0]    z_in [CORDIC_ITERS];
  logic                    v_in [CORDIC_ITERS];
  tvp_ctl_t                c_in [CORDIC_ITERS];
  logic signed [AMT_W-1:0] a_in [CORDIC_ITERS];

  logic signed [CW-1:0]    x_q [CORDIC_ITERS];
  logic signed [CW-1:0]    y_q [CORDIC_ITERS];
  logic signed [CW-1:0]    z_q [CORDIC_ITERS];
  logic                    v_q [CORDIC_ITERS];
  tvp_ctl_t                c_q [CORDIC_ITERS];
  logic signed [AMT_W-1:0] a_q [CORDIC_ITERS];

  logic signed [CW-1:0]    x_d [CORDIC_ITERS];
  logic signed [CW-1:0]    y_d [CORDIC_ITERS];
  logic signed [CW-1:0]    z_d [CORDIC_ITERS];

  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign x_in[g] = CORDIC_K;
      assign y_in[g] = '0;
      assign z_in[g] = z_i;
      assign v_in[g] = vld_i;
      assign c_in[g] = ctl_i;
      assign a_in[g] = amt_i;
    end else begin : g_next
      assign x_in[g] = x_q[g-1];
      assign y_in[g] = y_q[g-1];
      assign z_in[g] = z_q[g-1];
      assign v_in[g] = v_q[g-1];
      assign c_in[g] = c_q[g-1];
      assign a_in[g] = a_q[g-1];
    end

    always_comb begin
      if (!z_in[g][CW-1]) begin
        x_d[g] = x_in[g] - (y_in[g] >>> g);
        y_d[g] = y_in[g] + (x_in[g] >>> g);
        z_d[g] = z_in[g] - ATAN_TAB[g];
      end else begin
        x_d[g] = x_in[g] + (y_in[g] >>> g);
        y_d[g] = y_in[g] - (x_in[g] >>> g);
        z_d[g] = z_in[g] + ATAN_TAB[g];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (adv_i) begin
        v_q[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[g] <= x_d[g];
        y_q[g] <= y_d[g];
        z_q[g] <= z_d[g];
        c_q[g] <= c_in[g];
        a_q[g] <= a_in[g];
      end
    end
  end

  assign vld_o = v_q[CORDIC_ITERS-1];
  assign ctl_o = c_q[CORDIC_ITERS-1];
  assign amt_o = a_q[CORDIC_ITERS-1];
  assign cos_o = x_q[CORDIC_ITERS-1];
  assign sin_o = y_q[CORDIC_ITERS-1];

endmodule

/* rtl/tvp_scale.sv */
// Length scaling stage of the turtle vector plotter: length times sine and
// cosine, rounded half up back to the position's fixed point.
// Depends on tvp_pkg.
module tvp_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              vld_i,
  input  tvp_pkg::tvp_ctl_t                 ctl_i,
  input  logic signed [tvp_pkg::AMT_W-1:0]  amt_i,
  input  logic signed [tvp_pkg::CW-1:0]     cos_i,
  input  logic signed [tvp_pkg::CW-1:0]     sin_i,
  output logic                              vld_o,
  output tvp_pkg::tvp_ctl_t                 ctl_o,
  output logic signed [tvp_pkg::DISP_W-1:0] dx_o,
  output logic signed [tvp_pkg::DISP_W-1:0] dy_o
);
  import tvp_pkg::*;

  localparam int PW = AMT_W + CW;
  localparam logic signed [PW-1:0] RoundHalf = PW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0]     prod_x, prod_y, sh_x, sh_y;
  logic                     vld_q;
  tvp_ctl_t                 ctl_q;
  logic signed [DISP_W-1:0] dx_q, dy_q;

  assign prod_x = PW'(amt_i) * PW'(sin_i);
  assign prod_y = PW'(amt_i) * PW'(cos_i);
  assign sh_x   = (prod_x + RoundHalf) >>> FRAC_BITS;
  assign sh_y   = (prod_y + RoundHalf) >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q <= ctl_i;
      dx_q  <= sh_x[DISP_W-1:0];
      dy_q  <= sh_y[DISP_W-1:0];
    end
  end

  assign vld_o = vld_q;
  assign ctl_o = ctl_q;
  assign dx_o  = dx_q;
  assign dy_o  = dy_q;

endmodule

/* rtl/tvp_pos.sv */
// Position accumulator and result register of the turtle vector plotter:
// adds the step, saturates, clears on home, and registers the drawn
// segment. Depends on tvp_pkg.
module tvp_pos #(
  parameter int POS_BITS = tvp_pkg::PosBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              vld_i,
  input  tvp_pkg::tvp_ctl_t                 ctl_i,
  input  logic signed [tvp_pkg::DISP_W-1:0] dx_i,
  input  logic signed [tvp_pkg::DISP_W-1:0] dy_i,
  output logic                              out_vld_o,
  output logic [tvp_pkg::COORD_W-1:0]       start_x_o,
  output logic [tvp_pkg::COORD_W-1:0]       start_y_o,
  output logic [tvp_pkg::COORD_W-1:0]       end_x_o,
  output logic [tvp_pkg::COORD_W-1:0]       end_y_o,
  output logic [tvp_pkg::COLOR_W-1:0]       seg_color_o,
  output logic                              clipped_o
);
  import tvp_pkg::*;

  localparam int SUM_W = ((POS_BITS > DISP_W) ? POS_BITS : DISP_W) + 1;
  localparam logic signed [SUM_W-1:0] PosMax = SUM_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] PosMin = -PosMax - SUM_W'(1);
  localparam logic signed [POS_BITS-1:0] PosYReset = POS_BITS'(256);

  logic signed [POS_BITS-1:0] pos_x_q, pos_y_q, new_x, new_y;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic                       clip_x, clip_y;
  logic                       out_vld_q;
  logic [COORD_W-1:0]         sx_q, sy_q, ex_q, ey_q;
  logic [COLOR_W-1:0]         color_q;
  logic                       clip_q, emit;

  assign sum_x = SUM_W'(pos_x_q) + SUM_W'(dx_i);
  assign sum_y = SUM_W'(pos_y_q) + SUM_W'(dy_i);

  always_comb begin
    clip_x = 1'b1;
    clip_y = 1'b1;
    if (sum_x > PosMax) new_x = PosMax[POS_BITS-1:0];
    else if (sum_x < PosMin) new_x = PosMin[POS_BITS-1:0];
    else begin
      new_x  = sum_x[POS_BITS-1:0];
      clip_x = 1'b0;
    end
    if (sum_y > PosMax) new_y = PosMax[POS_BITS-1:0];
    else if (sum_y < PosMin) new_y = PosMin[POS_BITS-1:0];
    else begin
      new_y  = sum_y[POS_BITS-1:0];
      clip_y = 1'b0;
    end
  end

  assign emit = vld_i & ctl_i.is_move & ctl_i.pen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= PosYReset;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      out_vld_q <= emit;
      if (vld_i && ctl_i.is_move) begin
        pos_x_q <= new_x;
        pos_y_q <= new_y;
      end else if (vld_i && ctl_i.is_home) begin
        pos_x_q <= '0;
        pos_y_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && emit) begin
      sx_q    <= COORD_W'(pos_x_q);
      sy_q    <= COORD_W'(pos_y_q);
      ex_q    <= COORD_W'(new_x);
      ey_q    <= COORD_W'(new_y);
      color_q <= ctl_i.color;
      clip_q  <= clip_x | clip_y;
    end
  end

  assign out_vld_o   = out_vld_q;
  assign start_x_o   = sx_q;
  assign start_y_o   = sy_q;
  assign end_x_o     = ex_q;
  assign end_y_o     = ey_q;
  assign seg_color_o = color_q;
  assign clipped_o   = clip_q;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for turtle_vector_plotter: directed table, then random command
// streams, checked against a bit-exact CORDIC turtle predictor. Depends on tvp_pkg and
// the RTL top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tvp_pkg::*;

  localparam int     CMD_TARGET   = 1800;
  localparam int     STALL_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     ROTATIONS    = 16;
  localparam longint CORDIC_GAIN  = 64'sd652032874;
  localparam longint ROUND_HALF   = 64'sd536870912;
  localparam longint POS_MAX      = 64'sd8388607;
  localparam longint POS_MIN      = -64'sd8388608;

  localparam longint ARCTAN_STEP [ROTATIONS] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
  };

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] color;
    logic               clipped;
  } segment_t;

  typedef struct packed {
    cmd_e                op;
    logic [AMOUNT_W-1:0] amount;
    logic [COLOR_W-1:0]  color;
    logic                typed;
    segment_t            want;
  } script_row_t;

  localparam segment_t NO_SEG = '0;

  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_PEN_DOWN, 16'h0000, 3'd0, 1'b0, NO_SEG},
    '{CMD_FWD,      16'h0100, 3'd5, 1'b1,
      '{24'h000000, 24'h000100, 24'h000000, 24'h000200, 3'd0, 1'b0}},
    '{CMD_HOME,     16'h8000, 3'd7, 1'b0, NO_SEG},
    '{CMD_BACK,     16'h0100, 3'd0, 1'b1,
      '{24'h000000, 24'h000000, 24'h000000, 24'hFFFF00, 3'd0, 1'b0}},
    '{CMD_COLOR,    16'h7FFF, 3'd7, 1'b0, NO_SEG},
    '{CMD_FWD,      16'h7FFF, 3'd0, 1'b0, NO_SEG},
    '{CMD_RIGHT,    16'h4000, 3'd2, 1'b0, NO_SEG},
    '{CMD_FWD,      16'h8000, 3'd0, 1'b0, NO_SEG},
    '{CMD_BACK,     16'h8000, 3'd0, 1'b0, NO_SEG},
    '{CMD_LEFT,     16'h8000, 3'd0, 1'b0, NO_SEG},
    '{CMD_RIGHT,    16'h7FFF, 3'd0, 1'b0, NO_SEG},
    '{CMD_FWD,      16'h0000, 3'd0, 1'b0, NO_SEG},
    '{CMD_RIGHT,    16'hFFFF, 3'd0, 1'b0, NO_SEG},
    '{CMD_BACK,     16'hFFFF, 3'd0, 1'b0, NO_SEG},
    '{CMD_PEN_UP,   16'hFFFF, 3'd5, 1'b0, NO_SEG},
    '{CMD_FWD,      16'h3039, 3'd0, 1'b0, NO_SEG},
    '{CMD_COLOR,    16'h0000, 3'd3, 1'b0, NO_SEG},
    '{CMD_PEN_DOWN, 16'h1234, 3'd6, 1'b0, NO_SEG},
    '{CMD_LEFT,     16'h2000, 3'd0, 1'b0, NO_SEG},
    '{CMD_BACK,     16'h03E8, 3'd0, 1'b0, NO_SEG},
    '{CMD_COLOR,    16'h5555, 3'd0, 1'b0, NO_SEG},
    '{CMD_FWD,      16'h00FF, 3'd0, 1'b0, NO_SEG},
    '{CMD_HOME,     16'h0001, 3'd1, 1'b0, NO_SEG},
    '{CMD_FWD,      16'h0080, 3'd0, 1'b0, NO_SEG}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [CMD_W-1:0]      s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  longint          turtle_x;
  longint          turtle_y;
  logic [15:0]     turtle_heading;
  bit              pen_down;
  logic [2:0]      pen_color;

  segment_t        pending_segments [$];
  int unsigned     mismatch_count;
  int unsigned     commands_sent;
  int unsigned     idle_cycles;
  bit              sender_quiet;
  bit              receiver_quiet;

  turtle_vector_plotter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void heading_sin_cos(input logic [15:0] hd, output longint sin_v,
                                          output longint cos_v);
    logic [31:0] th;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    bit          flip;
    int          i;
    th   = {hd, 16'h0000};
    flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
    if (flip) th = th + 32'h8000_0000;
    z = longint'($signed(th));
    x = CORDIC_GAIN;
    y = 0;
    for (i = 0; i < ROTATIONS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_STEP[i];
      end
      x = nx;
    end
    sin_v = flip ? -y : y;
    cos_v = flip ? -x : x;
  endfunction

  function automatic longint clamp_pos(input longint v, inout bit clip);
    if (v > POS_MAX) begin
      clip = 1'b1;
      return POS_MAX;
    end
    if (v < POS_MIN) begin
      clip = 1'b1;
      return POS_MIN;
    end
    return v;
  endfunction

  // Applies one command to the turtle state; returns 1 when a segment is drawn.
  function automatic bit plot_command(input cmd_e op, input logic [15:0] amount,
                                      input logic [2:0] color, output segment_t seg);
    longint len;
    longint sin_v;
    longint cos_v;
    longint nx;
    longint ny;
    bit     clip;
    seg  = NO_SEG;
    clip = 1'b0;
    case (op)
      CMD_FWD, CMD_BACK: begin
        len = longint'($signed(amount));
        if (op == CMD_BACK) len = -len;
        heading_sin_cos(turtle_heading, sin_v, cos_v);
        nx = clamp_pos(turtle_x + ((len * sin_v + ROUND_HALF) >>> 30), clip);
        ny = clamp_pos(turtle_y + ((len * cos_v + ROUND_HALF) >>> 30), clip);
        seg.start_x = turtle_x[23:0];
        seg.start_y = turtle_y[23:0];
        seg.end_x   = nx[23:0];
        seg.end_y   = ny[23:0];
        seg.color   = pen_color;
        seg.clipped = clip;
        turtle_x = nx;
        turtle_y = ny;
        return pen_down;
      end
      CMD_RIGHT:    turtle_heading = turtle_heading + amount;
      CMD_LEFT:     turtle_heading = turtle_heading - amount;
      CMD_PEN_DOWN: pen_down = 1'b1;
      CMD_PEN_UP:   pen_down = 1'b0;
      CMD_HOME: begin
        turtle_x = 0;
        turtle_y = 0;
      end
      default:      pen_color = color;
    endcase
    return 1'b0;
  endfunction

  task automatic send_command(input cmd_e op, input logic [15:0] amount,
                              input logic [2:0] color, input bit typed, input segment_t want);
    int unsigned gap;
    segment_t    predicted;
    gap = (sender_quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b00000, color, amount};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (plot_command(op, amount, color, predicted))
      pending_segments.push_back(typed ? want : predicted);
    commands_sent++;
    if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
  endtask

  task automatic wait_for_segments();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_segments.size() != 0);
  endtask

  task automatic send_random_command();
    int unsigned    pick;
    cmd_e           op;
    logic [15:0]    amount;
    logic [15:0]    corners [4];
    corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = CMD_FWD;
    else if (pick < 55) op = CMD_BACK;
    else if (pick < 65) op = CMD_RIGHT;
    else if (pick < 75) op = CMD_LEFT;
    else if (pick < 85) op = CMD_PEN_DOWN;
    else if (pick < 89) op = CMD_PEN_UP;
    else if (pick < 92) op = CMD_HOME;
    else                op = CMD_COLOR;
    amount = ($urandom_range(0, 4) == 0) ? corners[$urandom_range(0, 3)] : 16'($urandom);
    send_command(op, amount, 3'($urandom), 1'b0, NO_SEG);
  endtask

  // Long straight run at full length, far enough to pin the turtle at the edge.
  task automatic run_to_edge();
    int n;
    send_command(CMD_HOME, 16'($urandom), 3'($urandom), 1'b0, NO_SEG);
    send_command(CMD_RIGHT, 16'($urandom), 3'($urandom), 1'b0, NO_SEG);
    send_command(CMD_PEN_DOWN, 16'($urandom), 3'($urandom), 1'b0, NO_SEG);
    for (n = 0; n < 400; n++) begin
      if ($urandom_range(0, 1) == 0)
        send_command(CMD_FWD, 16'h7FFF, 3'($urandom), 1'b0, NO_SEG);
      else
        send_command(CMD_BACK, 16'h8000, 3'($urandom), 1'b0, NO_SEG);
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count < 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_segment(input logic [OUT_DATA_W-1:0] data);
    segment_t want;
    if (pending_segments.size() == 0) begin
      mismatch_count++;
      if (mismatch_count < 100)
        $display("%0t: unexpected segment, expected none, actual %0h", $time, data);
      return;
    end
    want = pending_segments.pop_front();
    check_field("start_x",   want.start_x, data[23:0]);
    check_field("start_y",   want.start_y, data[47:24]);
    check_field("end_x",     want.end_x,   data[71:48]);
    check_field("end_y",     want.end_y,   data[95:72]);
    check_field("seg_color", 24'(want.color),   24'(data[98:96]));
    check_field("clipped",   24'(want.clipped), 24'(data[99]));
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = (receiver_quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_segment(m_axis_tdata_o);
      if ($urandom_range(0, 29) == 0) receiver_quiet = !receiver_quiet;
    end
  end

  initial begin
    int row;
    int edge_runs;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_FWD;
    mismatch_count  = 0;
    commands_sent   = 0;
    idle_cycles     = 0;
    sender_quiet    = 1'b0;
    receiver_quiet  = 1'b0;
    edge_runs       = 0;
    turtle_x        = 0;
    turtle_y        = 256;
    turtle_heading  = '0;
    pen_down        = 1'b0;
    pen_color       = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (row = 0; row < SCRIPT_LEN; row++)
      send_command(SCRIPT[row].op, SCRIPT[row].amount, SCRIPT[row].color,
                   SCRIPT[row].typed, SCRIPT[row].want);
    wait_for_segments();

    while (commands_sent < CMD_TARGET) begin
      if (edge_runs < 2 && commands_sent >= 500 + 600 * edge_runs) begin
        run_to_edge();
        edge_runs++;
      end else if ($urandom_range(0, 99) < 2) begin
        wait_for_segments();
      end else begin
        send_random_command();
      end
    end

    wait_for_segments();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_segments.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
rtl/tvp_pkg.sv
rtl/tvp_front.sv
rtl/tvp_cordic.sv
rtl/tvp_scale.sv
rtl/tvp_pos.sv
rtl/turtle_vector_plotter.sv
verif/testbench.sv
